>>> sv/multi_line_edge_debouncer_core_macros.svh
// ---------------------------------------------------------------------------
// Multi-line edge debouncer assertion macros
// Shorthand for clocked concurrent checks, reset-qualified on rst_ni.
// ---------------------------------------------------------------------------
`ifndef MULTI_LINE_EDGE_DEBOUNCER_CORE_MACROS_SVH
`define MULTI_LINE_EDGE_DEBOUNCER_CORE_MACROS_SVH

// same-cycle implication
`define MLDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mlde_pkg.sv
// ---------------------------------------------------------------------------
// mlde_pkg
// Shared types and constants of the multi-line edge debouncer.
// ---------------------------------------------------------------------------
package mlde_pkg;

  // default line count and period register reset value
  localparam int unsigned LINES_DEF    = 32;
  localparam logic [63:0] PERIOD_RESET = 64'd200000000;

  // configuration register indexes
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  // input item kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // stream widths
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 136;

  // per-line record held in one cell
  typedef struct packed {
    logic        level;
    logic        settled;
    logic        cand_level;
    logic [63:0] cand_time;
    logic [63:0] rise_time;
    logic [63:0] fall_time;
  } rec_t;

  // one report
  typedef struct packed {
    logic [63:0] fall_time;
    logic [63:0] rise_time;
    logic        settled;
    logic        level;
    logic [4:0]  line;
  } rep_t;

endpackage

>>> sv/multi_line_edge_debouncer_core.sv
// ---------------------------------------------------------------------------
// multi_line_edge_debouncer_core
// Per-line debouncer for timestamped edge events and idle tick sweeps.
//
//   channel   direction  transaction
//   s_axis    in         one edge event or one tick sweep request
//   m_axis    out        one line report, tlast on the final one of an item
//   cfg       in         one register write (index, data)
//
// Line records circulate through a ring of LINES cells, one record past the
// head update per cycle. An edge item waits for its line to reach the head;
// a tick sweep waits for line 0, then walks all lines. Reset clears every
// record at once; no clearing pass. The ring freezes while a new report
// finds the pending stage occupied and the output register full and not
// accepted.
// ---------------------------------------------------------------------------
module multi_line_edge_debouncer_core #(
  parameter int unsigned LINES = mlde_pkg::LINES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave stream: tdata = line[4:0], rising[5], time_ns[69:6], zero pad
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mlde_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser = kind
  input  logic                              s_axis_tuser,
  // master stream: tdata = report_line[4:0], level[5], settled[6],
  // rise_time[70:7], fall_time[134:71], zero pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mlde_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [63:0]                       cfg_data_i
);
  import mlde_pkg::*;

  localparam int unsigned PosW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(LINES - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EDGE  = 5'b00010,
    ST_TWAIT = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  state_e         state_q, state_d;
  logic [PosW-1:0] pos_q;
  logic [4:0]     line_q;
  logic           rising_q;
  logic [63:0]    time_q;
  logic [63:0]    period_q;
  logic [31:0]    enable_q;
  rep_t           pend_q;
  logic           pend_valid_q;
  rep_t           out_q;
  logic           out_last_q;
  logic           out_valid_q;

  rec_t           ring [LINES];
  rec_t           head_rec;
  rep_t           head_rep;
  logic           head_rep_valid;
  logic [LINES-1:0] en_vec;

  logic in_accept, out_free, stall, rotate;
  logic act_edge, act_tick, line_ok, pos_hit;
  logic load_mid, load_fin;

  // input fields
  logic [4:0]  in_line;
  logic        in_rising;
  logic [63:0] in_time;
  assign in_line   = s_axis_tdata[4:0];
  assign in_rising = s_axis_tdata[5];
  assign in_time   = s_axis_tdata[69:6];

  // handshakes
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      enable_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PERIOD: period_q <= cfg_data_i;
        REG_ENABLE: enable_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // per-line enable, lines from 32 up never debounce
  for (genvar k = 0; k < LINES; k++) begin : g_en
    if (k < 32) begin : g_lo
      assign en_vec[k] = enable_q[k];
    end else begin : g_hi
      assign en_vec[k] = 1'b0;
    end
  end

  // head activity
  assign line_ok  = {2'b00, in_line} < 7'(LINES);
  assign pos_hit  = {2'b00, line_q} == 7'(pos_q);
  assign act_edge = (state_q == ST_EDGE) && pos_hit;
  assign act_tick = (state_q == ST_SWEEP) || ((state_q == ST_TWAIT) && (pos_q == '0));

  assign stall  = head_rep_valid && pend_valid_q && !out_free;
  assign rotate = !stall;

  mlde_proc u_proc (
    .rec_i       (ring[0]),
    .act_edge_i  (act_edge),
    .act_tick_i  (act_tick),
    .rising_i    (rising_q),
    .time_i      (time_q),
    .period_i    (period_q),
    .en_i        (en_vec[pos_q]),
    .line_i      (5'(pos_q)),
    .rec_o       (head_rec),
    .rep_o       (head_rep),
    .rep_valid_o (head_rep_valid)
  );

  // record ring: cell k takes cell k+1, the last cell takes the head update
  for (genvar k = 0; k < LINES; k++) begin : g_ring
    rec_t nxt;
    if (k == LINES - 1) begin : g_tail
      assign nxt = head_rec;
    end else begin : g_mid
      assign nxt = ring[k+1];
    end
    mlde_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (rotate),
      .rec_i   (nxt),
      .rec_o   (ring[k])
    );
  end

  // index of the record at the head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (rotate) begin
      pos_q <= (pos_q == LastPos) ? '0 : pos_q + 1'b1;
    end
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      line_q   <= in_line;
      rising_q <= in_rising;
      time_q   <= in_time;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser == KIND_TICK) begin
            state_d = ST_TWAIT;
          end else if (line_ok) begin
            state_d = ST_EDGE;
          end
        end
      end
      ST_EDGE: begin
        if (act_edge && rotate) state_d = ST_FLUSH;
      end
      ST_TWAIT, ST_SWEEP: begin
        if (act_tick && rotate) begin
          state_d = (pos_q == LastPos) ? ST_FLUSH : ST_SWEEP;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // pending report: held until the next one or the end of the item decides tlast
  assign load_mid = rotate && head_rep_valid && pend_valid_q;
  assign load_fin = (state_q == ST_FLUSH) && pend_valid_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (rotate && head_rep_valid) begin
      pend_valid_q <= 1'b1;
    end else if (load_fin) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rotate && head_rep_valid) pend_q <= head_rep;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_mid || load_fin) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_mid || load_fin) begin
      out_q      <= pend_q;
      out_last_q <= load_fin;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};
  assign m_axis_tlast  = out_last_q;

  // checks
`include "multi_line_edge_debouncer_core_macros.svh"

  `MLDE_ASSERT_NOW(a_idle_no_pend, s_axis_tready, !pend_valid_q, "pending report while idle")
  `MLDE_ASSERT_NOW(a_stall_cause, !rotate, out_valid_q && !m_axis_tready, "ring stalled without backpressure")
  `MLDE_ASSERT_NEXT(a_pos_step, rotate && (pos_q != LastPos), pos_q == PosW'($past(pos_q) + 1'b1), "head index did not advance")
  `MLDE_ASSERT_NEXT(a_flush_done, (state_q == ST_FLUSH) && !pend_valid_q, state_q == ST_IDLE, "flush did not return to idle")

endmodule

>>> sv/mlde_cell.sv
// ---------------------------------------------------------------------------
// mlde_cell
// One link of the record ring: holds a line record, takes the neighbor's
// record whenever the ring advances.
// ---------------------------------------------------------------------------
module mlde_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  mlde_pkg::rec_t rec_i,
  output mlde_pkg::rec_t rec_o
);
  import mlde_pkg::*;

  rec_t rec_q;

  // record register, cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (shift_i) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule

>>> sv/mlde_proc.sv
// ---------------------------------------------------------------------------
// mlde_proc
// Head update of the ring: applies an edge or a tick check to the record
// passing the head and flags a report.
// ---------------------------------------------------------------------------
module mlde_proc (
  input  mlde_pkg::rec_t rec_i,
  input  logic           act_edge_i,
  input  logic           act_tick_i,
  input  logic           rising_i,
  input  logic [63:0]    time_i,
  input  logic [63:0]    period_i,
  input  logic           en_i,
  input  logic [4:0]     line_i,
  output mlde_pkg::rec_t rec_o,
  output mlde_pkg::rep_t rep_o,
  output logic           rep_valid_o
);
  import mlde_pkg::*;

  logic [63:0] age;
  logic        expired;
  logic        cand_open;
  logic        level_new;

  // candidate age, wrapping modulo 2^64
  assign age       = time_i - rec_i.cand_time;
  assign expired   = age > period_i;
  assign cand_open = rec_i.cand_time != 64'd0;
  assign level_new = rising_i;

  always_comb begin
    rec_o       = rec_i;
    rep_valid_o = 1'b0;
    if (act_edge_i) begin
      // edge: level and edge time first
      rec_o.level = level_new;
      if (rising_i) begin
        rec_o.rise_time = time_i;
      end else begin
        rec_o.fall_time = time_i;
      end
      if (en_i) begin
        rec_o.settled = 1'b0;
        if (!cand_open) begin
          rec_o.cand_time  = time_i;
          rec_o.cand_level = level_new;
        end else if (rec_i.cand_level != level_new) begin
          rec_o.cand_time = 64'd0;
        end else if (expired) begin
          rec_o.settled   = 1'b1;
          rec_o.cand_time = 64'd0;
          rep_valid_o     = 1'b1;
        end
      end else begin
        rep_valid_o = 1'b1;
      end
    end else if (act_tick_i) begin
      // tick: settle an enabled line whose candidate has expired
      if (en_i && !rec_i.settled && cand_open && expired) begin
        rec_o.settled   = 1'b1;
        rec_o.cand_time = 64'd0;
        rep_valid_o     = 1'b1;
      end
    end
  end

  // report fields come from the updated record
  assign rep_o.line      = line_i;
  assign rep_o.level     = rec_o.level;
  assign rep_o.settled   = rec_o.settled;
  assign rep_o.rise_time = rec_o.rise_time;
  assign rep_o.fall_time = rec_o.fall_time;

endmodule

>>> bench/multi_line_edge_debouncer_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_line_edge_debouncer_core_test
// Self-checking bench for the multi-line edge debouncer. A scoreboard keeps
// its own copy of every line record and of both registers, and predicts the
// line reports for each accepted edge or tick. Each received report is
// compared field by field. Directed cases come first, then random phases,
// each under its own period, most under a new enable mask. Both streams idle in random
// bursts; the final phase runs with no idling.
// ---------------------------------------------------------------------------
module multi_line_edge_debouncer_core_test;
  import mlde_pkg::*;

  localparam int unsigned LINES        = LINES_DEF;
  // worst in-flight time of a tick sweep, plus margin
  localparam int unsigned SETTLE_CYCLES = 2 * LINES + 40;
  localparam longint unsigned LIMIT_CYCLES = 2_000_000;
  localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // one expected report, with its end-of-item marker
  typedef struct {
    rep_t rep;
    logic last;
  } line_report_t;

  // -------------------------------------------------------------------------
  // Scoreboard: per-line records, register shadow, pending reports
  // -------------------------------------------------------------------------
  class debounce_scoreboard;
    logic [63:0] period;
    logic [31:0] enable_mask;
    logic        level_q      [LINES];
    logic        cand_level_q [LINES];
    logic        settled_q    [LINES];
    logic [63:0] cand_time_q  [LINES];
    logic [63:0] rise_q       [LINES];
    logic [63:0] fall_q       [LINES];
    line_report_t reports_due[$];
    int unsigned mismatches;

    function new();
      period      = PERIOD_RESET;
      enable_mask = '0;
      mismatches  = 0;
      for (int i = 0; i < LINES; i++) begin
        level_q[i]      = 1'b0;
        cand_level_q[i] = 1'b0;
        settled_q[i]    = 1'b0;
        cand_time_q[i]  = '0;
        rise_q[i]       = '0;
        fall_q[i]       = '0;
      end
    endfunction

    function void note_config(logic idx, logic [63:0] val);
      if (idx == REG_PERIOD) period = val;
      else enable_mask = val[31:0];
    endfunction

    function void queue_report(int unsigned ln, logic last);
      line_report_t r;
      r.rep.line      = ln[4:0];
      r.rep.level     = level_q[ln];
      r.rep.settled   = settled_q[ln];
      r.rep.rise_time = rise_q[ln];
      r.rep.fall_time = fall_q[ln];
      r.last          = last;
      reports_due.push_back(r);
    endfunction

    // advance the line records by one accepted item, queue its reports
    function void predict_reports(logic kind, logic [4:0] ln, logic rise,
                                  logic [63:0] t);
      logic        report;
      logic [63:0] age;
      int unsigned n;
      report = 1'b0;
      n      = 0;
      if (kind == KIND_EDGE) begin
        if (rise) begin
          rise_q[ln]  = t;
          level_q[ln] = 1'b1;
        end else begin
          fall_q[ln]  = t;
          level_q[ln] = 1'b0;
        end
        if (enable_mask[ln]) begin
          settled_q[ln] = 1'b0;
          age = t - cand_time_q[ln];
          if (cand_time_q[ln] == '0) begin
            cand_time_q[ln]  = t;
            cand_level_q[ln] = level_q[ln];
          end else if (cand_level_q[ln] != level_q[ln]) begin
            cand_time_q[ln] = '0;
          end else if (age > period) begin
            settled_q[ln]   = 1'b1;
            cand_time_q[ln] = '0;
            report          = 1'b1;
          end
        end else begin
          report = 1'b1;
        end
        if (report) queue_report(ln, 1'b1);
      end else begin
        // sweep in line order; the last report of the sweep carries tlast
        for (int i = 0; i < LINES; i++) begin
          age = t - cand_time_q[i];
          if (enable_mask[i] && !settled_q[i] && cand_time_q[i] != '0 &&
              age > period) begin
            settled_q[i]   = 1'b1;
            cand_time_q[i] = '0;
            queue_report(i, 1'b0);
            n++;
          end
        end
        if (n > 0) reports_due[reports_due.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_result(rep_t got, logic got_last);
      line_report_t exp;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected report line %0d at %0t", got.line, $realtime);
        return;
      end
      exp = reports_due.pop_front();
      if (got.line !== exp.rep.line || got.level !== exp.rep.level ||
          got.settled !== exp.rep.settled || got.rise_time !== exp.rep.rise_time ||
          got.fall_time !== exp.rep.fall_time || got_last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: report at %0t", $realtime);
          $display("  exp line %0d level %b settled %b rise %h fall %h last %b",
                   exp.rep.line, exp.rep.level, exp.rep.settled,
                   exp.rep.rise_time, exp.rep.fall_time, exp.last);
          $display("  got line %0d level %b settled %b rise %h fall %h last %b",
                   got.line, got.level, got.settled, got.rise_time,
                   got.fall_time, got_last);
        end
      end
    endfunction

    function int unsigned final_errors();
      if (reports_due.size() != 0) begin
        $display("ERROR: %0d reports never arrived", reports_due.size());
        mismatches += reports_due.size();
      end
      return mismatches;
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT signals
  // -------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_index_i   = 1'b0;
  logic [63:0]           cfg_data_i    = '0;

  logic                  idle_on = 1'b1;
  debounce_scoreboard    sb = new();

  multi_line_edge_debouncer_core #(
    .LINES(LINES)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #(LIMIT_CYCLES * 10);
    $display("Mismatches found");
    $finish;
  end

  // report stream: random stall bursts while idle_on is set
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  // report monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(rep_t'(m_axis_tdata[$bits(rep_t)-1:0]), m_axis_tlast);
  end

  // -------------------------------------------------------------------------
  // Drivers; all called right after a rising edge
  // -------------------------------------------------------------------------
  task automatic send_item(logic kind, logic [4:0] ln, logic rise, logic [63:0] t);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, t, rise, ln};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.predict_reports(kind, ln, rise, t);
  endtask

  // hold off until all reports are in and the line ring has gone quiet
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.note_config(idx, val);
  endtask

  // random phase: bouncing edges on a few hot lines, ticks, full sweeps, noise
  task automatic run_random(int unsigned n_items, logic [63:0] start_time);
    logic [63:0] now;
    logic [31:0] span;
    logic [4:0]  hot_base;
    logic [3:0]  hot_level;
    logic        rise;
    int unsigned sent;
    int unsigned sel;
    int unsigned j;
    now       = start_time;
    span      = (sb.period > 64'd1_000_000_000) ? 32'd1_000_000_000 : sb.period[31:0];
    hot_base  = 5'($urandom);
    hot_level = 4'($urandom);
    sent      = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        // open candidates on every line, then sweep once the period is past
        for (int i = 0; i < LINES; i++)
          send_item(KIND_EDGE, i[4:0], 1'($urandom_range(0, 1)), now + 64'(i));
        now = now + 64'(LINES) + sb.period + 64'd1;
        send_item(KIND_TICK, 5'($urandom), 1'($urandom), now);
        sent += LINES + 1;
      end else if (sel < 24) begin
        send_item(KIND_TICK, 5'($urandom), 1'($urandom), now);
        sent++;
      end else if (sel < 30) begin
        send_item(1'($urandom), 5'($urandom), 1'($urandom), {$urandom, $urandom});
        sent++;
      end else begin
        j = $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) hot_level[j] = ~hot_level[j];
        rise = ($urandom_range(0, 3) == 0) ? ~hot_level[j] : hot_level[j];
        send_item(KIND_EDGE, hot_base + j[4:0], rise, now);
        sent++;
      end
      if ($urandom_range(0, 39) == 0) hot_base = 5'($urandom);
      now = now + 64'($urandom_range(0, span + span / 2 + 1));
    end
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: no debounce, every edge reports; ticks stay silent
    send_item(KIND_EDGE, 5'd0,  1'b1, 64'd0);
    send_item(KIND_EDGE, 5'd31, 1'b0, T_MAX);
    send_item(KIND_EDGE, 5'd21, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(KIND_EDGE, 5'd10, 1'b0, 64'h5555_5555_5555_5555);
    send_item(KIND_TICK, 5'd31, 1'b1, T_MAX);
    wait_idle();

    write_reg(REG_PERIOD, 64'd100);
    write_reg(REG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFF);
    // candidate opened at time zero reads as none
    send_item(KIND_EDGE, 5'd3, 1'b1, 64'd0);
    send_item(KIND_EDGE, 5'd3, 1'b1, 64'd50);
    send_item(KIND_EDGE, 5'd3, 1'b1, 64'd151);
    send_item(KIND_EDGE, 5'd3, 1'b1, 64'd160);
    // opposite edge drops the candidate
    send_item(KIND_EDGE, 5'd4, 1'b1, 64'd10);
    send_item(KIND_EDGE, 5'd4, 1'b0, 64'd20);
    send_item(KIND_EDGE, 5'd4, 1'b0, 64'd500);
    send_item(KIND_EDGE, 5'd5, 1'b1, 64'd1000);
    // sweep settling two lines, then the third
    send_item(KIND_TICK, 5'd0, 1'b0, 64'd1050);
    send_item(KIND_TICK, 5'd0, 1'b0, 64'd1101);
    // age wraps around the top of the time range
    send_item(KIND_EDGE, 5'd6, 1'b1, T_MAX - 64'd9);
    send_item(KIND_TICK, 5'd0, 1'b0, 64'd91);
    // age equal to the period is not enough
    send_item(KIND_EDGE, 5'd7, 1'b1, 64'd2000);
    send_item(KIND_EDGE, 5'd7, 1'b1, 64'd2100);
    send_item(KIND_EDGE, 5'd7, 1'b1, 64'd2101);
    wait_idle();

    // random phases
    write_reg(REG_PERIOD, 64'd0);
    run_random(60, 64'd0);
    wait_idle();
    write_reg(REG_PERIOD, T_MAX);
    run_random(60, {$urandom, $urandom});
    wait_idle();
    write_reg(REG_PERIOD, PERIOD_RESET);
    write_reg(REG_ENABLE, {$urandom, 32'h0});
    run_random(60, 64'd1);
    wait_idle();
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_PERIOD, 64'($urandom_range(1, 5000)));
      write_reg(REG_ENABLE, {$urandom, $urandom | $urandom});
      run_random(60, 64'($urandom));
      wait_idle();
    end
    write_reg(REG_PERIOD, {$urandom, $urandom});
    write_reg(REG_ENABLE, {$urandom, $urandom});
    run_random(60, {$urandom, $urandom});
    wait_idle();

    // final phase without idling on either side
    idle_on = 1'b0;
    write_reg(REG_PERIOD, 64'($urandom_range(1, 300)));
    write_reg(REG_ENABLE, {$urandom, 32'hFFFF_FFFF});
    run_random(60, 64'($urandom));
    wait_idle();

    if (sb.final_errors() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/mlde_pkg.sv
sv/mlde_cell.sv
sv/mlde_proc.sv
sv/multi_line_edge_debouncer_core.sv
bench/multi_line_edge_debouncer_core_test.sv
